@@ hw/rtl/pipc_pkg.sv @@
// ----------------------------------------------------------------------------
// pipc_pkg
// Shared types and constants of the point-in-polygons collision test.
// ----------------------------------------------------------------------------
package pipc_pkg;

   localparam int COORD_W    = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int POLY_IDX_W = 3;
   localparam int VTX_IDX_W  = 4;
   localparam int COUNT_W    = 5;
   localparam int PIU_W      = 4;
   localparam int WIND_W     = 6;
   localparam int LOAD_POLYS = 1 << POLY_IDX_W;
   localparam int LOAD_VTXS  = 1 << VTX_IDX_W;
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // register index is paddr[2]
   localparam logic REG_POLYGONS_IN_USE = 1'b0;

   typedef struct packed {
      logic                 load_we;
      logic                 start;
      logic                 issue;
      logic                 edge_slot;
      logic                 last;
      logic [PIU_W-1:0]     poly;
      logic [COUNT_W-1:0]   vtx;
      logic                 load_result;
   } cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   count;
      logic [PIU_W-1:0]     poly_limit;
      logic                 pipe_busy;
   } status_type;

endpackage

@@ hw/rtl/pipc_req_if.sv @@
// ----------------------------------------------------------------------------
// pipc_req_if
// Request channel: vertex loads and point queries.
// ----------------------------------------------------------------------------
interface pipc_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [pipc_pkg::POLY_IDX_W-1:0]     polygon_index;
   logic [pipc_pkg::VTX_IDX_W-1:0]      vertex_index;
   logic signed [pipc_pkg::COORD_W-1:0] coord_x;
   logic signed [pipc_pkg::COORD_W-1:0] coord_y;
   logic                                final_vertex;

   modport source (
      output valid, kind, polygon_index, vertex_index, coord_x, coord_y, final_vertex,
      input  ready
   );
   modport sink (
      input  valid, kind, polygon_index, vertex_index, coord_x, coord_y, final_vertex,
      output ready
   );
endinterface

@@ hw/rtl/pipc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pipc_rsp_if
// Response channel: collision result of one query.
// ----------------------------------------------------------------------------
interface pipc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             collides;
   logic [pipc_pkg::POLY_IDX_W-1:0]  hit_polygon;

   modport source (
      output valid, collides, hit_polygon,
      input  ready
   );
   modport sink (
      input  valid, collides, hit_polygon,
      output ready
   );
endinterface

@@ hw/rtl/pipc_datapath.sv @@
// ----------------------------------------------------------------------------
// pipc_datapath
// Vertex store, edge pipeline (read, differences, products, winding count)
// and result register.
// ----------------------------------------------------------------------------
module pipc_datapath #(
   parameter int MAX_POLYGONS = 8,
   parameter int MAX_VERTICES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pipc_pkg::cmd_type                    cmd,
   output pipc_pkg::status_type                 status,
   input  logic [pipc_pkg::PIU_W-1:0]           polygons_in_use,
   input  logic [pipc_pkg::POLY_IDX_W-1:0]      req_polygon_index,
   input  logic [pipc_pkg::VTX_IDX_W-1:0]       req_vertex_index,
   input  logic signed [pipc_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [pipc_pkg::COORD_W-1:0]  req_coord_y,
   input  logic                                 req_final_vertex,
   output logic                                 rsp_collides,
   output logic [pipc_pkg::POLY_IDX_W-1:0]      rsp_hit_polygon
);

   localparam int PP    = (MAX_POLYGONS < pipc_pkg::LOAD_POLYS) ?
                          MAX_POLYGONS : pipc_pkg::LOAD_POLYS;
   localparam int PV    = (MAX_VERTICES < pipc_pkg::LOAD_VTXS) ?
                          MAX_VERTICES : pipc_pkg::LOAD_VTXS;
   localparam int DEPTH = PP * PV;
   localparam int AW    = $clog2(DEPTH);
   localparam int PIW   = (PP > 1) ? $clog2(PP) : 1;
   localparam int CW    = pipc_pkg::COORD_W;
   localparam int DW    = pipc_pkg::DIFF_W;
   localparam int MW    = pipc_pkg::PROD_W;
   localparam int WW    = pipc_pkg::WIND_W;
   localparam int PIU_EXT = pipc_pkg::PIU_W + 7;

   logic [2*CW-1:0]                 vertex_mem [DEPTH];
   logic [pipc_pkg::COUNT_W-1:0]    counts_ff [PP];

   logic                            load_ok;
   logic [AW-1:0]                   wr_addr;
   logic [AW-1:0]                   rd_addr;

   logic signed [CW-1:0]            px_ff, py_ff;
   logic signed [CW-1:0]            prev_x_ff, prev_y_ff;

   logic                            s1_valid_ff, s1_edge_ff, s1_last_ff;
   logic [pipc_pkg::PIU_W-1:0]      s1_poly_ff;
   logic signed [CW-1:0]            s1_x_ff, s1_y_ff;

   logic                            s2_valid_ff, s2_last_ff, s2_up_ff, s2_down_ff;
   logic [pipc_pkg::PIU_W-1:0]      s2_poly_ff;
   logic signed [DW-1:0]            s2_ax_ff, s2_ay_ff, s2_bx_ff, s2_by_ff;

   logic                            s3_valid_ff, s3_last_ff, s3_up_ff, s3_down_ff;
   logic [pipc_pkg::PIU_W-1:0]      s3_poly_ff;
   logic signed [MW-1:0]            s3_p1_ff, s3_p2_ff;

   logic signed [WW-1:0]            wind_ff, wind_in, wind_sum;
   logic                            any_ff, any_in;
   logic [pipc_pkg::POLY_IDX_W-1:0] hit_ff, hit_in;

   logic                            rsp_collides_ff;
   logic [pipc_pkg::POLY_IDX_W-1:0] rsp_hit_ff;

   logic signed [DW-1:0]            ax, ay, bx, by;
   logic                            up, down;

   // load path
   assign load_ok = cmd.load_we
                    && (int'(req_polygon_index) < MAX_POLYGONS)
                    && (int'(req_vertex_index) < MAX_VERTICES);
   assign wr_addr = AW'(int'(req_polygon_index) * PV + int'(req_vertex_index));
   assign rd_addr = AW'(int'(cmd.poly) * PV + int'(cmd.vtx));

   always_ff @(posedge clock) begin
      if (load_ok) begin
         vertex_mem[wr_addr] <= {req_coord_x, req_coord_y};
      end
      if (cmd.issue) begin
         {s1_x_ff, s1_y_ff} <= vertex_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PP; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (load_ok && req_final_vertex) begin
         counts_ff[req_polygon_index[PIW-1:0]] <=
            pipc_pkg::COUNT_W'(req_vertex_index) + pipc_pkg::COUNT_W'(1);
      end
   end

   // status
   always_comb begin
      status.count      = (int'(cmd.poly) < PP) ? counts_ff[cmd.poly[PIW-1:0]] : '0;
      status.poly_limit = ((PIU_EXT'(polygons_in_use)) > PIU_EXT'(MAX_POLYGONS)) ?
                          pipc_pkg::PIU_W'(MAX_POLYGONS) : polygons_in_use;
      status.pipe_busy  = s1_valid_ff | s2_valid_ff | s3_valid_ff;
   end

   // edge geometry: previous vertex to current vertex
   assign ax   = {s1_x_ff[CW-1], s1_x_ff} - {prev_x_ff[CW-1], prev_x_ff};
   assign ay   = {s1_y_ff[CW-1], s1_y_ff} - {prev_y_ff[CW-1], prev_y_ff};
   assign bx   = {px_ff[CW-1], px_ff} - {prev_x_ff[CW-1], prev_x_ff};
   assign by   = {py_ff[CW-1], py_ff} - {prev_y_ff[CW-1], prev_y_ff};
   assign up   = (prev_y_ff <= py_ff) && (s1_y_ff > py_ff);
   assign down = (prev_y_ff > py_ff) && (s1_y_ff <= py_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff <= req_coord_x;
         py_ff <= req_coord_y;
      end
      if (s1_valid_ff) begin
         prev_x_ff <= s1_x_ff;
         prev_y_ff <= s1_y_ff;
      end
      s1_edge_ff <= cmd.edge_slot;
      s1_last_ff <= cmd.last;
      s1_poly_ff <= cmd.poly;
      s2_last_ff <= s1_last_ff;
      s2_poly_ff <= s1_poly_ff;
      s2_up_ff   <= up;
      s2_down_ff <= down;
      s2_ax_ff   <= ax;
      s2_ay_ff   <= ay;
      s2_bx_ff   <= bx;
      s2_by_ff   <= by;
      s3_last_ff <= s2_last_ff;
      s3_poly_ff <= s2_poly_ff;
      s3_up_ff   <= s2_up_ff;
      s3_down_ff <= s2_down_ff;
      s3_p1_ff   <= MW'(s2_ax_ff * s2_by_ff);
      s3_p2_ff   <= MW'(s2_ay_ff * s2_bx_ff);
      if (cmd.load_result) begin
         rsp_collides_ff <= any_ff;
         rsp_hit_ff      <= hit_ff;
      end
   end

   // winding count
   always_comb begin
      wind_sum = wind_ff;
      if (s3_up_ff && (s3_p1_ff > s3_p2_ff)) begin
         wind_sum = wind_ff + WW'(1);
      end else if (s3_down_ff && (s3_p1_ff < s3_p2_ff)) begin
         wind_sum = wind_ff - WW'(1);
      end
      wind_in = wind_ff;
      any_in  = any_ff;
      hit_in  = hit_ff;
      if (cmd.start) begin
         wind_in = '0;
         any_in  = 1'b0;
         hit_in  = '0;
      end else if (s3_valid_ff) begin
         if (s3_last_ff) begin
            wind_in = '0;
            if (wind_sum != '0) begin
               any_in = 1'b1;
               hit_in = s3_poly_ff[pipc_pkg::POLY_IDX_W-1:0];
            end
         end else begin
            wind_in = wind_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         wind_ff     <= '0;
         any_ff      <= 1'b0;
         hit_ff      <= '0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff && s1_edge_ff;
         s3_valid_ff <= s2_valid_ff;
         wind_ff     <= wind_in;
         any_ff      <= any_in;
         hit_ff      <= hit_in;
      end
   end

   assign rsp_collides    = rsp_collides_ff;
   assign rsp_hit_polygon = rsp_hit_ff;

endmodule

@@ hw/rtl/pipc_controller.sv @@
// ----------------------------------------------------------------------------
// pipc_controller
// Request handshake and edge walk sequencer: one vertex read per cycle,
// polygon by polygon, then result hand-off.
// ----------------------------------------------------------------------------
module pipc_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_kind,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pipc_pkg::cmd_type       cmd,
   input  pipc_pkg::status_type    status
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [pipc_pkg::PIU_W-1:0]       poly_ff, poly_in;
   logic [pipc_pkg::COUNT_W-1:0]     vtx_ff, vtx_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      poly_in      = poly_ff;
      vtx_in       = vtx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;

      cmd             = '0;
      cmd.poly        = poly_ff;
      cmd.vtx         = vtx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == pipc_pkg::KIND_QUERY) begin
                  cmd.start = 1'b1;
                  poly_in   = '0;
                  vtx_in    = '0;
                  state_in  = ST_SCAN;
               end else begin
                  cmd.load_we = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (poly_ff >= status.poly_limit) begin
               state_in = ST_DRAIN;
            end else if (status.count == '0) begin
               poly_in = poly_ff + pipc_pkg::PIU_W'(1);
               vtx_in  = '0;
            end else begin
               cmd.issue     = 1'b1;
               cmd.edge_slot = (vtx_ff != '0);
               cmd.last      = (vtx_ff == status.count);
               // closing edge: read the first vertex again
               if (vtx_ff == status.count) begin
                  cmd.vtx = '0;
                  poly_in = poly_ff + pipc_pkg::PIU_W'(1);
                  vtx_in  = '0;
               end else begin
                  vtx_in  = vtx_ff + pipc_pkg::COUNT_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && (!rsp_valid_ff || rsp_ready)) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         poly_ff      <= '0;
         vtx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         poly_ff      <= poly_in;
         vtx_ff       <= vtx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/point_in_polygons_collision_test.sv @@
// ----------------------------------------------------------------------------
// point_in_polygons_collision_test
// Winding-number point-in-polygon test over a set of stored polygons.
// ----------------------------------------------------------------------------
// A vertex load is taken while the block is idle. A query walks the edges
// of every polygon in use through the single read port of the vertex
// memory, one vertex a cycle, skipping each empty polygon without a read;
// the edge pipeline (read, differences, 33x33 products, winding count)
// drains before the result is registered. The result waits in an output
// register, so vertex loads and the next query are taken while it is
// pending. The polygons_in_use register sits at byte address 0 of the APB
// port; it must be written only while the block is idle, which the block
// itself does not enforce.
// ----------------------------------------------------------------------------
module point_in_polygons_collision_test #(
   parameter int MAX_POLYGONS = 8,
   parameter int MAX_VERTICES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   pipc_req_if.sink                           req_ch,
   pipc_rsp_if.source                         rsp_ch,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pipc_pkg::PADDR_W-1:0]       paddr,
   input  logic [pipc_pkg::PDATA_W-1:0]       pwdata,
   output logic [pipc_pkg::PDATA_W-1:0]       prdata,
   output logic                               pready
);

   pipc_pkg::cmd_type               cmd;
   pipc_pkg::status_type            status;
   logic [pipc_pkg::PIU_W-1:0]      piu_ff, piu_in;
   logic                            csr_we;

   assign pready = 1'b1;
   assign csr_we = psel && penable && pwrite
                   && (paddr[2] == pipc_pkg::REG_POLYGONS_IN_USE);
   assign piu_in = csr_we ? pwdata[pipc_pkg::PIU_W-1:0] : piu_ff;
   assign prdata = (paddr[2] == pipc_pkg::REG_POLYGONS_IN_USE) ?
                   pipc_pkg::PDATA_W'(piu_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         piu_ff <= '0;
      end else begin
         piu_ff <= piu_in;
      end
   end

   pipc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   pipc_datapath #(
      .MAX_POLYGONS (MAX_POLYGONS),
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .polygons_in_use   (piu_ff),
      .req_polygon_index (req_ch.polygon_index),
      .req_vertex_index  (req_ch.vertex_index),
      .req_coord_x       (req_ch.coord_x),
      .req_coord_y       (req_ch.coord_y),
      .req_final_vertex  (req_ch.final_vertex),
      .rsp_collides      (rsp_ch.collides),
      .rsp_hit_polygon   (rsp_ch.hit_polygon)
   );

endmodule

@@ tb/sv/pipc_collision_checker.sv @@
// ----------------------------------------------------------------------------
// pipc_collision_checker
// Watches the request, response and register ports of the collision test,
// keeps its own copy of the polygon tables and the polygons_in_use register,
// works out the winding-number verdict of every accepted query and compares
// each accepted response with the oldest verdict still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pipc_collision_checker (
   input  logic                         clock,
   input  logic                         reset,
   pipc_req_if                          req_ch,
   pipc_rsp_if                          rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pipc_pkg::PADDR_W-1:0] paddr,
   input  logic [pipc_pkg::PDATA_W-1:0] pwdata,
   input  logic                         pready,
   output int                           failures,
   output int                           pending
);

   typedef struct packed {
      logic                            collides;
      logic [pipc_pkg::POLY_IDX_W-1:0] hit_polygon;
   } collision_type;

   localparam logic [pipc_pkg::PADDR_W-1:0] IN_USE_ADDR =
      {pipc_pkg::REG_POLYGONS_IN_USE, 2'b00};

   logic signed [pipc_pkg::COORD_W-1:0] vertex_x [pipc_pkg::LOAD_POLYS][pipc_pkg::LOAD_VTXS];
   logic signed [pipc_pkg::COORD_W-1:0] vertex_y [pipc_pkg::LOAD_POLYS][pipc_pkg::LOAD_VTXS];
   logic [pipc_pkg::COUNT_W-1:0]        vertex_count [pipc_pkg::LOAD_POLYS];
   logic [pipc_pkg::PIU_W-1:0]          polys_in_use;
   collision_type                       awaited_collisions [$];

   function automatic bit encloses(input int unsigned poly,
                                   input logic signed [pipc_pkg::COORD_W-1:0] px,
                                   input logic signed [pipc_pkg::COORD_W-1:0] py);
      logic signed [67:0] x1, y1, x2, y2, turn;
      int                 winding;
      int unsigned        n, i, j;
      winding = 0;
      n = vertex_count[poly];
      for (i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         x1 = vertex_x[poly][i];
         y1 = vertex_y[poly][i];
         x2 = vertex_x[poly][j];
         y2 = vertex_y[poly][j];
         turn = (x2 - x1) * (py - y1) - (y2 - y1) * (px - x1);
         if (y1 <= py) begin
            if (y2 > py && turn > 0) winding++;
         end else if (y2 <= py && turn < 0) begin
            winding--;
         end
      end
      return winding != 0;
   endfunction

   function automatic collision_type predict_collision(
      input logic signed [pipc_pkg::COORD_W-1:0] px,
      input logic signed [pipc_pkg::COORD_W-1:0] py);
      collision_type verdict;
      int unsigned   used, p;
      verdict = '0;
      used = (polys_in_use > pipc_pkg::LOAD_POLYS) ? pipc_pkg::LOAD_POLYS : polys_in_use;
      for (p = 0; p < used; p++) begin
         if (encloses(p, px, py)) begin
            verdict.collides    = 1'b1;
            verdict.hit_polygon = pipc_pkg::POLY_IDX_W'(p);
         end
      end
      return verdict;
   endfunction

   task automatic report_mismatch(input string what, input int expected, input int got);
      $display("%0t collision checker: %s expected %0d got %0d", $realtime, what, expected, got);
      failures++;
   endtask

   always @(posedge clock) begin
      collision_type want;
      collision_type fresh;
      if (reset) begin
         foreach (vertex_count[p]) vertex_count[p] = '0;
         polys_in_use = '0;
         awaited_collisions.delete();
         failures = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_collisions.size() == 0) begin
               report_mismatch("response with no query awaiting it, collides", -1,
                               rsp_ch.collides);
            end else begin
               want = awaited_collisions.pop_front();
               if (rsp_ch.collides !== want.collides)
                  report_mismatch("collides", want.collides, rsp_ch.collides);
               if (rsp_ch.hit_polygon !== want.hit_polygon)
                  report_mismatch("hit_polygon", want.hit_polygon, rsp_ch.hit_polygon);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.kind == pipc_pkg::KIND_LOAD) begin
               vertex_x[req_ch.polygon_index][req_ch.vertex_index] = req_ch.coord_x;
               vertex_y[req_ch.polygon_index][req_ch.vertex_index] = req_ch.coord_y;
               if (req_ch.final_vertex)
                  vertex_count[req_ch.polygon_index] = {1'b0, req_ch.vertex_index} + 5'd1;
            end else begin
               fresh = predict_collision(req_ch.coord_x, req_ch.coord_y);
               awaited_collisions = {awaited_collisions, fresh};
            end
         end
         if (psel && penable && pwrite && pready && paddr == IN_USE_ADDR)
            polys_in_use = pwdata[pipc_pkg::PIU_W-1:0];
      end
      pending <= awaited_collisions.size();
   end

endmodule

@@ tb/sv/point_in_polygons_collision_test_test.sv @@
// ----------------------------------------------------------------------------
// point_in_polygons_collision_test_test
// Drives vertex loads, point queries and polygons_in_use writes into the
// collision test with random gaps and response stalls. A directed opening
// covers extreme coordinates, degenerate polygons and register saturation;
// random phases then build well-formed polygons mixed with stray loads and
// queries. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_polygons_collision_test_test;

   typedef enum int unsigned {SPAN_GRID, SPAN_NEAR, SPAN_FULL, SPAN_EXTREME} span_type;

   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          REST_CYCLES  = 200;
   localparam int          PHASES       = 10;
   localparam int          PHASE_ITEMS  = 125;
   localparam logic [pipc_pkg::PADDR_W-1:0] IN_USE_ADDR =
      {pipc_pkg::REG_POLYGONS_IN_USE, 2'b00};
   localparam logic signed [pipc_pkg::COORD_W-1:0] ONE  = 32'sh0001_0000;
   localparam logic signed [pipc_pkg::COORD_W-1:0] CMIN = 32'sh8000_0000;
   localparam logic signed [pipc_pkg::COORD_W-1:0] CMAX = 32'sh7FFF_FFFF;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           psel, penable, pwrite, pready;
   logic [pipc_pkg::PADDR_W-1:0]   paddr;
   logic [pipc_pkg::PDATA_W-1:0]   pwdata, prdata;
   int                             failures, pending;
   int                             cycles = 0;
   bit                             gaps_on, stalls_on;
   logic [pipc_pkg::LOAD_VTXS-1:0] written [pipc_pkg::LOAD_POLYS];
   logic signed [pipc_pkg::COORD_W-1:0] shape_x [pipc_pkg::LOAD_POLYS][pipc_pkg::LOAD_VTXS];
   logic signed [pipc_pkg::COORD_W-1:0] shape_y [pipc_pkg::LOAD_POLYS][pipc_pkg::LOAD_VTXS];

   pipc_req_if req_ch();
   pipc_rsp_if rsp_ch();

   point_in_polygons_collision_test i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   pipc_collision_checker i_checker (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .pready   (pready),
      .failures (failures),
      .pending  (pending)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("point_in_polygons_collision_test_test: errors");
         $finish;
      end
   end

   initial begin
      int unsigned hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = stalls_on ? $urandom_range(0, 7) : 0;
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   function automatic span_type draw_span();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return SPAN_GRID;
      if (r < 80) return SPAN_NEAR;
      if (r < 95) return SPAN_FULL;
      return SPAN_EXTREME;
   endfunction

   function automatic logic signed [pipc_pkg::COORD_W-1:0] pick_coord(input span_type span);
      case (span)
         SPAN_GRID: begin
            return 32'(int'($urandom_range(0, 8)) - 4) << 16;
         end
         SPAN_NEAR: begin
            return 32'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
         end
         SPAN_FULL: begin
            return $urandom;
         end
         default: begin
            case ($urandom_range(0, 2))
               0: return CMIN;
               1: return CMAX;
               default: return '0;
            endcase
         end
      endcase
   endfunction

   task automatic send_request(input logic kind, input logic [pipc_pkg::POLY_IDX_W-1:0] p,
                               input logic [pipc_pkg::VTX_IDX_W-1:0] v,
                               input logic signed [pipc_pkg::COORD_W-1:0] x,
                               input logic signed [pipc_pkg::COORD_W-1:0] y, input logic fin);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.kind          <= kind;
      req_ch.polygon_index <= p;
      req_ch.vertex_index  <= v;
      req_ch.coord_x       <= x;
      req_ch.coord_y       <= y;
      req_ch.final_vertex  <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic load_vertex(input int unsigned p, input int unsigned v,
                              input logic signed [pipc_pkg::COORD_W-1:0] x,
                              input logic signed [pipc_pkg::COORD_W-1:0] y, input logic fin);
      written[p][v] = 1'b1;
      shape_x[p][v] = x;
      shape_y[p][v] = y;
      send_request(pipc_pkg::KIND_LOAD, pipc_pkg::POLY_IDX_W'(p), pipc_pkg::VTX_IDX_W'(v),
                   x, y, fin);
   endtask

   task automatic query_point(input logic signed [pipc_pkg::COORD_W-1:0] x,
                              input logic signed [pipc_pkg::COORD_W-1:0] y);
      send_request(pipc_pkg::KIND_QUERY, pipc_pkg::POLY_IDX_W'($urandom),
                   pipc_pkg::VTX_IDX_W'($urandom), x, y, 1'($urandom));
   endtask

   // drop valid, wait for every awaited response, then let the block go quiet
   task automatic drain_and_rest();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (REST_CYCLES) @(posedge clock);
   endtask

   task automatic write_in_use(input logic [pipc_pkg::PIU_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= IN_USE_ADDR;
      pwdata  <= {28'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      int unsigned sent, n, p, v, phase;
      span_type    span;
      logic        fin;
      logic [16:0] need;
      logic signed [pipc_pkg::COORD_W-1:0] qx, qy;

      gaps_on = 1'b1;
      stalls_on = 1'b1;
      foreach (written[i]) written[i] = '0;
      reset                <= 1'b1;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.kind          <= pipc_pkg::KIND_LOAD;
      req_ch.polygon_index <= '0;
      req_ch.vertex_index  <= '0;
      req_ch.coord_x       <= '0;
      req_ch.coord_y       <= '0;
      req_ch.final_vertex  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      drain_and_rest();
      write_in_use(4'd8);
      load_vertex(0, 0, -ONE, -ONE, 1'b0);
      load_vertex(0, 1, -ONE, ONE, 1'b0);
      load_vertex(0, 2, ONE, ONE, 1'b0);
      load_vertex(0, 3, ONE, -ONE, 1'b1);
      load_vertex(1, 0, CMIN, CMIN, 1'b0);
      load_vertex(1, 1, CMIN, CMAX, 1'b0);
      load_vertex(1, 2, CMAX, CMIN, 1'b1);
      load_vertex(2, 0, 5 * ONE, 5 * ONE, 1'b1);
      load_vertex(3, 0, '0, '0, 1'b0);
      load_vertex(3, 1, 2 * ONE, 2 * ONE, 1'b0);
      load_vertex(3, 2, 4 * ONE, 4 * ONE, 1'b1);
      load_vertex(7, 15, CMAX, CMIN, 1'b0);
      query_point('0, '0);
      query_point(32'sh0000_8000, 32'sh0000_8000);
      query_point(CMAX, CMAX);
      query_point(CMIN, CMIN);
      query_point(ONE, '0);
      query_point(5 * ONE, 5 * ONE);
      query_point(2 * ONE, 2 * ONE);
      drain_and_rest();
      write_in_use(4'd15);
      query_point('0, '0);
      drain_and_rest();
      write_in_use(4'd0);
      query_point('0, '0);

      for (phase = 0; phase < PHASES; phase++) begin
         drain_and_rest();
         write_in_use(phase == 0 ? 4'd8 : phase == 1 ? 4'd9 :
                      pipc_pkg::PIU_W'($urandom_range(0, 15)));
         gaps_on = (phase % 3 != 2);
         stalls_on = (phase % 4 != 1);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            case ($urandom_range(0, 99)) inside
               [0:39]: begin
                  p = $urandom_range(0, pipc_pkg::LOAD_POLYS - 1);
                  n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
                  span = draw_span();
                  for (v = 0; v < n; v++)
                     load_vertex(p, v, pick_coord(span), pick_coord(span), v == n - 1);
                  sent += n;
               end
               [40:87]: begin
                  p = $urandom_range(0, pipc_pkg::LOAD_POLYS - 1);
                  v = $urandom_range(0, pipc_pkg::LOAD_VTXS - 1);
                  if ($urandom_range(0, 9) == 0 && written[p][v]) begin
                     qx = shape_x[p][v];
                     qy = shape_y[p][v];
                  end else begin
                     span = draw_span();
                     qx = pick_coord(span);
                     qy = pick_coord(span);
                  end
                  query_point(qx, qy);
                  sent++;
               end
               default: begin
                  p = $urandom_range(0, pipc_pkg::LOAD_POLYS - 1);
                  v = $urandom_range(0, pipc_pkg::LOAD_VTXS - 1);
                  need = (17'd1 << (v + 1)) - 17'd1;
                  fin = $urandom_range(0, 1) &&
                        (((written[p] | (16'd1 << v)) & need[15:0]) == need[15:0]);
                  span = draw_span();
                  load_vertex(p, v, pick_coord(span), pick_coord(span), fin);
                  sent++;
               end
            endcase
         end
      end

      drain_and_rest();
      if (failures == 0 && pending == 0) begin
         $display("point_in_polygons_collision_test_test: clean");
      end else begin
         $display("point_in_polygons_collision_test_test: errors");
      end
      $finish;
   end

endmodule

@@ point_in_polygons_collision_test.f @@
hw/rtl/pipc_pkg.sv
hw/rtl/pipc_req_if.sv
hw/rtl/pipc_rsp_if.sv
hw/rtl/pipc_datapath.sv
hw/rtl/pipc_controller.sv
hw/rtl/point_in_polygons_collision_test.sv
tb/sv/pipc_collision_checker.sv
tb/sv/point_in_polygons_collision_test_test.sv
